[hw/rtl/sat_pkg.sv]
// ----------------------------------------------------------------------------
// sat_pkg: shared types and codes for the sorted array table
// Opcodes, status codes and the controller-to-datapath command struct.
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_SEARCH = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_REWIND = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;
  localparam logic [2:0] OP_SPARE0 = 3'd6;
  localparam logic [2:0] OP_SPARE1 = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_ABSENT   = 2'd2;
  localparam logic [1:0] ST_PAST_END = 2'd3;

  typedef struct packed {
    logic load;      // capture opcode and key, start search
    logic bs_step;   // advance the binary search: issue a read of mid or consume it
    logic mv_step;   // one shift step
    logic mv_init;   // set up the shift index
    logic finish;    // form the result
  } sat_cmd_t;

  typedef struct packed {
    logic bs_done;
    logic need_move; // operation shifts entries
    logic mv_done;
    logic rd_done;   // final memory read at lo or cursor is ready
  } sat_sts_t;

endpackage

[hw/rtl/sat_ctrl.sv]
// ----------------------------------------------------------------------------
// sat_ctrl: sequencer for the sorted array table
// Steps load, binary search, entry shift and result phases.
// ----------------------------------------------------------------------------
module sat_ctrl
  import sat_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_valid,
  input  sat_sts_t sts,
  output sat_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_BS   = 5'b00010,
    S_MVI  = 5'b00100,
    S_MV   = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !out_valid;
        if (in_valid && !out_valid) begin
          cmd.load = 1'b1;
          state_next = S_BS;
        end
      end
      S_BS: begin
        if (sts.bs_done) begin
          if (sts.rd_done) begin
            if (sts.need_move) begin
              state_next = S_MVI;
            end else begin
              state_next = S_FIN;
            end
          end
        end else begin
          cmd.bs_step = 1'b1;
        end
      end
      S_MVI: begin
        cmd.mv_init = 1'b1;
        state_next = S_MV;
      end
      S_MV: begin
        cmd.mv_step = 1'b1;
        if (sts.mv_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hw/rtl/sat_dp.sv]
// ----------------------------------------------------------------------------
// sat_dp: datapath for the sorted array table
// Entry memory, binary search, one-entry-per-step shift and result regs.
// ----------------------------------------------------------------------------
module sat_dp
  import sat_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32,
  parameter int AW = $clog2(CAPACITY),
  parameter int CW = $clog2(CAPACITY + 1)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [2:0]  opcode,
  input  logic [31:0] key_value,
  input  sat_cmd_t    cmd,
  output sat_sts_t    sts,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [31:0] result_value,
  output logic        found,
  output logic [1:0]  status,
  output logic [6:0]  entry_count,
  output logic        is_full,
  output logic        is_empty
);

  logic [KEY_BITS-1:0] mem [CAPACITY];
  logic [KEY_BITS-1:0] rdata;
  logic [AW-1:0]       raddr;
  logic                wen;
  logic [AW-1:0]       waddr;
  logic [KEY_BITS-1:0] wdata;

  logic [2:0]          op;
  logic [KEY_BITS-1:0] key;
  logic [CW-1:0]       count;
  logic [CW-1:0]       cursor;
  logic [CW-1:0]       lo, hi;
  logic                rd_pend;  // a read of mid is in flight
  logic                rd_ok;    // rdata holds the addressed entry
  logic [CW-1:0]       mv;
  logic [CW-1:0]       mid;
  logic                hit;
  logic                full_now;
  logic                moved;

  assign full_now = (count == CW'(CAPACITY));
  assign mid = lo + ((hi - lo) >> 1);
  assign hit = (lo < count) && (rdata == key);

  // Search runs while lo < hi; each step issues a read and then consumes it.
  always_comb begin
    sts.bs_done = (lo >= hi) && !rd_pend;
    sts.rd_done = rd_ok;
    sts.need_move = 1'b0;
    if (op == OP_INSERT && !full_now) sts.need_move = 1'b1;
    if (op == OP_DELETE && hit) sts.need_move = 1'b1;
    if (op == OP_INSERT) sts.mv_done = (mv <= lo);
    else                 sts.mv_done = (mv + 1'b1 >= count);
  end

  always_comb begin
    raddr = lo[AW-1:0];
    if (cmd.mv_init) begin
      if (op == OP_INSERT) raddr = AW'(count - 1'b1);
      else                 raddr = AW'(lo + 1'b1);
    end else if (cmd.mv_step) begin
      if (op == OP_INSERT) raddr = AW'(mv - 2'd2);
      else                 raddr = AW'(mv + 2'd2);
    end else if (cmd.bs_step && !rd_pend) begin
      raddr = mid[AW-1:0];
    end else if (op == OP_READ) begin
      raddr = cursor[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (wen) mem[waddr] <= wdata;
  end

  // Shift step: rdata holds the neighbor read last cycle.
  always_comb begin
    wen = 1'b0;
    waddr = mv[AW-1:0];
    wdata = rdata;
    if (cmd.mv_step) begin
      if (op == OP_INSERT) begin
        wen = 1'b1;
        if (mv <= lo) wdata = key;
      end else if (mv + 1'b1 < count) begin
        wen = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cursor    <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
      rd_ok     <= 1'b0;
      lo        <= '0;
      hi        <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.load) begin
        op  <= opcode;
        key <= KEY_BITS'(key_value);
        lo  <= '0;
        hi  <= (opcode == OP_INSERT || opcode == OP_SEARCH || opcode == OP_DELETE)
               ? count : '0;
        rd_pend <= 1'b0;
        rd_ok   <= 1'b0;
        moved   <= 1'b0;
      end else if (cmd.bs_step) begin
        if (!rd_pend) begin
          rd_pend <= 1'b1;
        end else begin
          rd_pend <= 1'b0;
          if (rdata < key) lo <= mid + 1'b1;
          else             hi <= mid;
        end
      end else if (!rd_ok) begin
        rd_ok <= 1'b1;   // final read at lo or cursor lands next cycle
      end
      if (cmd.mv_init) begin
        mv    <= (op == OP_INSERT) ? count : lo;
        moved <= 1'b1;
      end
      if (cmd.mv_step) begin
        if (op == OP_INSERT) mv <= mv - 1'b1;
        else                 mv <= mv + 1'b1;
      end
      if (cmd.finish) begin
        out_valid    <= 1'b1;
        result_value <= '0;
        found        <= 1'b0;
        status       <= ST_OK;
        case (op)
          OP_INSERT: begin
            if (full_now) status <= ST_FULL;
            else count <= count + 1'b1;
          end
          OP_SEARCH: begin
            if (hit) begin
              found        <= 1'b1;
              result_value <= 32'(rdata);
            end
          end
          OP_DELETE: begin
            if (moved) count <= count - 1'b1;
            else status <= ST_ABSENT;
          end
          OP_CLEAR:  count <= '0;
          OP_REWIND: cursor <= '0;
          OP_READ: begin
            if (cursor < count) begin
              result_value <= 32'(rdata);
              cursor <= cursor + 1'b1;
            end else begin
              status <= ST_PAST_END;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign entry_count = 7'(count);
  assign is_full     = (count == CW'(CAPACITY));
  assign is_empty    = (count == '0);

endmodule

[hw/rtl/sorted_array_table.sv]
// ----------------------------------------------------------------------------
// sorted_array_table: ordered key table with insert, search, delete, read
// Keys kept ascending in a single-port-write memory; one transaction at a time.
// ----------------------------------------------------------------------------
// A transaction runs k binary search steps, where k is at most
// ceil(log2(count+1)), and k is zero for clear, rewind, read next and unused
// opcodes. An insert into a table that is not full then shifts entries up, one
// entry per cycle; a delete that finds its key shifts the entries above it down,
// with at least one shift step. Each search step issues a read on the entry
// memory's registered read port and then consumes it. A new transaction is taken
// once the previous result has been delivered. Memory needs no clearing pass
// after reset.
module sorted_array_table
  import sat_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [31:0] key_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_value,
  output logic        found,
  output logic [1:0]  status,
  output logic [6:0]  entry_count,
  output logic        is_full,
  output logic        is_empty
);

  sat_cmd_t cmd;
  sat_sts_t sts;

  sat_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .sts, .cmd
  );

  sat_dp #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_dp (
    .clk, .rst, .opcode, .key_value, .cmd, .sts, .out_ready, .out_valid,
    .result_value, .found, .status, .entry_count, .is_full, .is_empty
  );

  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    !(is_full && is_empty)) else $error("full and empty together");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accept while result pending");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (status == ST_OK)) else $error("found with bad status");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: sorted array table testbench
// Drives table operations over a valid/ready channel and predicts every
// response with an in-bench copy of the ordered table, cursor and count.
// ----------------------------------------------------------------------------
module tb
  import sat_pkg::*;
();

  localparam int CAP = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] value;
    logic        hit;
    logic [1:0]  st;
    logic [6:0]  cnt;
    logic        full;
    logic        empty;
  } table_resp_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  opcode;
  logic [31:0] key_value;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] result_value;
  logic        found;
  logic [1:0]  status;
  logic [6:0]  entry_count;
  logic        is_full;
  logic        is_empty;

  logic [31:0] keys_q[$];
  int unsigned cursor_pos;
  table_resp_t pending_resp_q[$];
  int          mismatch_cnt;
  int          idle_cycles;
  int unsigned rx_hold;

  sorted_array_table u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic int unsigned first_not_below(logic [31:0] k);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = keys_q.size();
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (keys_q[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic table_resp_t apply_table_op(logic [2:0] op, logic [31:0] k);
    table_resp_t r;
    int unsigned pos;
    r = '0;
    r.st = ST_OK;
    pos = first_not_below(k);
    case (op)
      OP_INSERT: begin
        if (keys_q.size() >= CAP) r.st = ST_FULL;
        else keys_q.insert(pos, k);
      end
      OP_SEARCH: begin
        if (pos < keys_q.size() && keys_q[pos] == k) begin
          r.hit = 1'b1;
          r.value = keys_q[pos];
        end
      end
      OP_DELETE: begin
        if (pos < keys_q.size() && keys_q[pos] == k) keys_q.delete(pos);
        else r.st = ST_ABSENT;
      end
      OP_CLEAR: keys_q.delete();
      OP_REWIND: cursor_pos = 0;
      OP_READ: begin
        if (cursor_pos < keys_q.size()) begin
          r.value = keys_q[cursor_pos];
          cursor_pos++;
        end else begin
          r.st = ST_PAST_END;
        end
      end
      default: ;
    endcase
    r.cnt = 7'(keys_q.size());
    r.full = (keys_q.size() == CAP);
    r.empty = (keys_q.size() == 0);
    return r;
  endfunction

  task automatic send_op(logic [2:0] op, logic [31:0] k);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    key_value <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_resp_q.push_back(apply_table_op(op, k));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_resp_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 4))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  task automatic test_directed();
    send_op(OP_READ, 0);
    send_op(OP_DELETE, 32'h5);
    send_op(OP_SEARCH, 32'h5);
    send_op(OP_INSERT, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 32'h0);
    send_op(OP_INSERT, 32'h8000_0000);
    send_op(OP_INSERT, 32'h8000_0000);
    send_op(OP_INSERT, 32'h7FFF_FFFF);
    send_op(OP_SEARCH, 32'hFFFF_FFFF);
    send_op(OP_SEARCH, 32'h0);
    send_op(OP_SEARCH, 32'h1234_5678);
    send_op(OP_REWIND, 32'hFFFF_FFFF);
    repeat (6) send_op(OP_READ, 32'hAAAA_5555);
    send_op(OP_DELETE, 32'h8000_0000);
    send_op(OP_CLEAR, 32'h5555_AAAA);
    send_op(OP_READ, 0);
    send_op(OP_SPARE0, 32'hFFFF_FFFF);
    send_op(OP_SPARE1, 32'h0);
    drain();
  endtask

  task automatic test_fill_to_full();
    send_op(OP_CLEAR, 0);
    repeat (CAP + 3) send_op(OP_INSERT, pick_key());
    send_op(OP_REWIND, 0);
    repeat (CAP + 1) send_op(OP_READ, 0);
    while (keys_q.size() > 0) send_op(OP_DELETE, keys_q[$urandom_range(0, keys_q.size() - 1)]);
    send_op(OP_DELETE, 0);
    drain();
  endtask

  task automatic test_random_mix();
    int unsigned sel;
    logic [31:0] k;
    repeat (800) begin
      sel = $urandom_range(0, 99);
      k = pick_key();
      if (keys_q.size() > 0 && $urandom_range(0, 1) == 0)
        k = keys_q[$urandom_range(0, keys_q.size() - 1)];
      if (sel < 35) send_op(OP_INSERT, k);
      else if (sel < 55) send_op(OP_SEARCH, k);
      else if (sel < 75) send_op(OP_DELETE, k);
      else if (sel < 78) send_op(OP_CLEAR, k);
      else if (sel < 84) send_op(OP_REWIND, k);
      else if (sel < 98) send_op(OP_READ, k);
      else send_op(($urandom_range(0, 1) == 0) ? OP_SPARE0 : OP_SPARE1, k);
    end
    drain();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold <= 0;
    end else begin
      if (rx_hold != 0) begin
        rx_hold <= rx_hold - 1;
        out_ready <= 1'b0;
      end else begin
        rx_hold <= gap_len();
        out_ready <= 1'b1;
      end
      if (out_valid && out_ready) begin
        if (pending_resp_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected response value=%h", result_value);
        end else begin
          table_resp_t e;
          e = pending_resp_q.pop_front();
          if (e !== {result_value, found, status, entry_count, is_full, is_empty}) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch exp val=%h hit=%b st=%0d cnt=%0d f=%b e=%b got val=%h hit=%b st=%0d cnt=%0d f=%b e=%b",
                e.value, e.hit, e.st, e.cnt, e.full, e.empty,
                result_value, found, status, entry_count, is_full, is_empty);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OP_INSERT;
    key_value = '0;
    out_ready = 1'b0;
    mismatch_cnt = 0;
    idle_cycles = 0;
    cursor_pos = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fill_to_full();
    test_random_mix();
    repeat (200) @(posedge clk);
    if (mismatch_cnt == 0 && pending_resp_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
